// ----- hdl/i2cmbs_pkg.sv -----
`default_nettype none

package i2cmbs_pkg;

  localparam int unsigned HalfPeriodW     = 16;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned BitIdxW         = 4;
  localparam int unsigned DataBits        = 8;
  localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd250;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // levels and status for one beat on the result channel
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] read_byte;
    logic             ack_seen;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/i2cmbs_core.sv -----
`default_nettype none

module i2cmbs_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               step,
  input  wire logic [i2cmbs_pkg::HalfPeriodW-1:0] half_period,
  input  wire logic                               req_valid,
  input  wire logic [1:0]                         command,
  input  wire logic [i2cmbs_pkg::ByteW-1:0]       data_byte,
  input  wire logic                               ack_level,
  input  wire logic                               sda_in,
  output i2cmbs_pkg::res_t                        res
);
  import i2cmbs_pkg::*;

  logic [HalfPeriodW-1:0] divider_count, divider_count_next;
  logic                   phase, phase_next;
  logic [BitIdxW-1:0]     bit_index, bit_index_next;
  logic [ByteW-1:0]       shift_reg, shift_reg_next;
  cmd_t                   active_command, active_command_next;
  logic                   busy_flag, busy_flag_next;
  logic                   scl_level, scl_level_next;
  logic                   sda_level, sda_level_next;
  logic                   ack_level_hold, ack_level_hold_next;
  logic [ByteW-1:0]       read_hold, read_hold_next;
  logic                   ack_hold, ack_hold_next;
  logic                   done;

  logic [HalfPeriodW-1:0] hp;
  logic                   phase_last;
  logic [BitIdxW-1:0]     bit_inc;

  // SDA for a data or ack bit, set while SCL is low
  function automatic logic drive_sda(cmd_t c, logic [BitIdxW-1:0] idx,
                                     logic [ByteW-1:0] sh, logic ackl);
    logic data_phase;
    data_phase = (idx < BitIdxW'(DataBits));
    if (c == CMD_WRITE) return data_phase ? sh[ByteW-1] : 1'b1;
    else                return data_phase ? 1'b1 : ackl;
  endfunction

  assign hp         = (half_period == '0) ? HalfPeriodW'(1) : half_period;
  assign phase_last = ({1'b0, divider_count} + (HalfPeriodW+1)'(1)) >= {1'b0, hp};
  assign bit_inc    = bit_index + BitIdxW'(1);

  always_comb begin
    divider_count_next  = divider_count;
    phase_next          = phase;
    bit_index_next      = bit_index;
    shift_reg_next      = shift_reg;
    active_command_next = active_command;
    busy_flag_next      = busy_flag;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    ack_level_hold_next = ack_level_hold;
    read_hold_next      = read_hold;
    ack_hold_next       = ack_hold;
    done                = 1'b0;

    if (busy_flag) begin
      if (phase_last) begin
        divider_count_next = '0;
        case (active_command)
          CMD_START: begin
            if (!phase) begin
              sda_level_next = 1'b0;
              phase_next     = 1'b1;
            end else begin
              scl_level_next = 1'b0;
              done           = 1'b1;
            end
          end
          CMD_STOP: begin
            if (!phase) begin
              scl_level_next = 1'b1;
              phase_next     = 1'b1;
            end else begin
              sda_level_next = 1'b1;
              done           = 1'b1;
            end
          end
          default: begin
            if (!phase) begin
              scl_level_next = 1'b1;
              phase_next     = 1'b1;
            end else begin
              // sample at the end of the SCL-high half
              if (active_command == CMD_WRITE) begin
                if (bit_index < BitIdxW'(DataBits)) shift_reg_next = {shift_reg[ByteW-2:0], 1'b0};
                else                                ack_hold_next  = sda_in;
              end else if (bit_index < BitIdxW'(DataBits)) begin
                shift_reg_next = {shift_reg[ByteW-2:0], sda_in};
              end
              scl_level_next = 1'b0;
              bit_index_next = bit_inc;
              if (bit_inc > BitIdxW'(DataBits)) begin
                if (active_command == CMD_READ) read_hold_next = shift_reg_next;
                done = 1'b1;
              end else begin
                phase_next     = 1'b0;
                sda_level_next = drive_sda(active_command, bit_inc, shift_reg_next,
                                           ack_level_hold);
              end
            end
          end
        endcase
        if (done) begin
          busy_flag_next     = 1'b0;
          phase_next         = 1'b0;
          bit_index_next     = '0;
          divider_count_next = '0;
        end
      end else begin
        divider_count_next = divider_count + HalfPeriodW'(1);
      end
    end else if (req_valid) begin
      active_command_next = cmd_t'(command);
      shift_reg_next      = data_byte;
      ack_level_hold_next = ack_level;
      busy_flag_next      = 1'b1;
      phase_next          = 1'b0;
      bit_index_next      = '0;
      divider_count_next  = '0;
      case (cmd_t'(command))
        CMD_START: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
        CMD_STOP: sda_level_next = 1'b0;
        default: begin
          scl_level_next = 1'b0;
          sda_level_next = drive_sda(cmd_t'(command), '0, data_byte, ack_level);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count  <= '0;
      phase          <= 1'b0;
      bit_index      <= '0;
      shift_reg      <= '0;
      active_command <= CMD_START;
      busy_flag      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      ack_level_hold <= 1'b0;
      read_hold      <= '0;
      ack_hold       <= 1'b0;
    end else if (step) begin
      divider_count  <= divider_count_next;
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      shift_reg      <= shift_reg_next;
      active_command <= active_command_next;
      busy_flag      <= busy_flag_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      ack_level_hold <= ack_level_hold_next;
      read_hold      <= read_hold_next;
      ack_hold       <= ack_hold_next;
    end
  end

  // levels after this beat's update
  assign res.scl       = scl_level_next;
  assign res.sda       = sda_level_next;
  assign res.busy      = busy_flag_next;
  assign res.done      = done;
  assign res.read_byte = read_hold_next;
  assign res.ack_seen  = ack_hold_next;

endmodule

`default_nettype wire

// ----- hdl/i2c_master_byte_sequencer_top.sv -----
// The result of an input beat is captured in the output register when the beat is accepted.
// Throughput: one input beat per cycle; the output register lets a new beat in while the
// previous result is being taken, so input stalls only while the output is held.
// Bus phases are paced by the 16-bit divider, advanced once per accepted beat.
// Reset (rst, synchronous): sequencer idle, SCL and SDA released, half period 250.
`default_nettype none

module i2c_master_byte_sequencer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [i2cmbs_pkg::HalfPeriodW-1:0] cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               req_valid,
  input  wire logic [1:0]                         command,
  input  wire logic [i2cmbs_pkg::ByteW-1:0]       data_byte,
  input  wire logic                               ack_level,
  input  wire logic                               sda_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    scl_out,
  output logic                                    sda_out,
  output logic                                    busy_res,
  output logic                                    done_res,
  output logic [i2cmbs_pkg::ByteW-1:0]            read_byte,
  output logic                                    ack_seen
);
  import i2cmbs_pkg::*;

  logic [HalfPeriodW-1:0] half_period;
  res_t                   res;
  res_t                   res_q;
  logic                   in_beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) half_period <= HalfPeriodReset;
    else if (cfg_valid) half_period <= cfg_data;
  end

  i2cmbs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_beat),
    .half_period (half_period),
    .req_valid   (req_valid),
    .command     (command),
    .data_byte   (data_byte),
    .ack_level   (ack_level),
    .sda_in      (sda_in),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) res_q <= res;
  end

  assign scl_out   = res_q.scl;
  assign sda_out   = res_q.sda;
  assign busy_res  = res_q.busy;
  assign done_res  = res_q.done;
  assign read_byte = res_q.read_byte;
  assign ack_seen  = res_q.ack_seen;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy in the same result beat");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result held");

endmodule

`default_nettype wire
